// ===== src/acphi_pkg.sv =====
package acphi_pkg;

  // input action codes
  localparam logic [2:0] ACT_HOST_REG = 3'd0;
  localparam logic [2:0] ACT_HOST_WR  = 3'd1;
  localparam logic [2:0] ACT_HOST_RD  = 3'd2;
  localparam logic [2:0] ACT_CPU_WR   = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;

  // host register offsets
  localparam logic [2:0] HREG_RESET = 3'd0;
  localparam logic [2:0] HREG_NMI   = 3'd1;
  localparam logic [2:0] HREG_RATE  = 3'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_PER_TICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_MULT     = 3'd4;

  localparam logic [8:0]  VOLUME_RESET       = 9'd256;
  localparam logic [7:0]  CLK_PER_TICK_RESET = 8'd81;
  localparam logic [4:0]  CLK_MULT_RESET     = 5'd4;
  localparam logic [31:0] COUNTER_LOAD       = 32'd255;
  localparam logic [31:0] COUNTER_MIN        = 32'h8000_0000;
  localparam logic [11:0] RUN_MAX            = 12'hFFF;
  localparam logic [11:0] RUN_RESET          = 12'd1024;
  localparam logic [7:0]  DAC_MID            = 8'h80;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CPU_RESET,
    OP_NMI,
    OP_RATE,
    OP_RAM_WR,
    OP_RAM_RD,
    OP_DAC_WR,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [8:0] volume;
    logic       mute;
    logic       paused;
    logic [7:0] clk_per_tick;
    logic [4:0] clk_mult;
  } cfg_t;

endpackage

// ===== src/acphi_front.sv =====
module acphi_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [15:0]        in_address,
  input  logic [7:0]         in_write_value,
  input  logic               q_full,
  output logic               push_valid,
  output acphi_pkg::item_t   push_item
);
  import acphi_pkg::*;

  op_t op_c;

  always_comb begin
    op_c = OP_NONE;
    case (in_action)
      ACT_HOST_REG: begin
        case (in_address[2:0])
          HREG_RESET: op_c = OP_CPU_RESET;
          HREG_NMI:   op_c = OP_NMI;
          HREG_RATE:  op_c = OP_RATE;
          default:    op_c = OP_NONE;
        endcase
      end
      ACT_HOST_WR: op_c = OP_RAM_WR;
      ACT_HOST_RD: op_c = OP_RAM_RD;
      // coprocessor writes with bit 15 set also hit the DAC latch
      ACT_CPU_WR:  op_c = in_address[15] ? OP_DAC_WR : OP_RAM_WR;
      ACT_TICK:    op_c = OP_TICK;
      default:     op_c = OP_NONE;
    endcase
  end

  assign in_ready       = !q_full;
  assign push_valid     = in_valid && !q_full;
  assign push_item.op   = op_c;
  assign push_item.addr = in_address;
  assign push_item.data = in_write_value;

endmodule

// ===== src/acphi_queue.sv =====
module acphi_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  acphi_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output acphi_pkg::item_t pop_item
);
  import acphi_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);

  item_t           entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign full      = (count_r == DepthCnt);
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

endmodule

// ===== src/acphi_back.sv =====
module acphi_back #(
  parameter int RAM_ADDR_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  acphi_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  acphi_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_read_data,
  output logic [15:0]      out_sample_out,
  output logic             out_irq_request,
  output logic             out_cpu_reset_request,
  output logic             out_nmi_request,
  output logic [11:0]      out_run_cycles
);
  import acphi_pkg::*;

  localparam int RamDepth = 1 << RAM_ADDR_BITS;

  logic [7:0] ram_r [RamDepth];
  logic [7:0] ram_rd_r;
  logic [RAM_ADDR_BITS-1:0] ram_addr;

  logic [7:0]  dac_r, dac_nxt;
  logic [31:0] counter_r, counter_nxt;
  logic [7:0]  period_r, period_nxt;
  logic        rst_pend_r, rst_pend_nxt;
  logic        running_r, running_nxt;
  logic [11:0] cpr_r, cpr_nxt;

  logic        out_valid_r;
  logic        rd_sel_r, rd_sel_nxt;
  logic [15:0] sample_r, sample_nxt;
  logic        irq_r, irq_nxt;
  logic        cpu_rst_r, cpu_rst_nxt;
  logic        nmi_r, nmi_nxt;
  logic [11:0] run_r, run_nxt;

  logic [8:0]  centered;
  logic [15:0] cen16, vol16, prod16;
  logic [32:0] diff;
  logic [31:0] sat;
  logic        underflow;
  logic [31:0] cnt_tick;
  logic [7:0]  rate_period;
  logic [12:0] run_prod;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign ram_addr = q_item.addr[RAM_ADDR_BITS-1:0];

  // centred DAC sample times volume, low 16 bits
  assign centered = {1'b0, dac_r} - {1'b0, DAC_MID};
  assign cen16    = {{7{centered[8]}}, centered};
  assign vol16    = {7'd0, cfg.volume};
  assign prod16   = cen16 * vol16;

  // counter step, saturating at the most negative value; a negative result adds the period
  assign diff      = {counter_r[31], counter_r} - {25'd0, cfg.clk_per_tick};
  assign sat       = (diff[32] && !diff[31]) ? COUNTER_MIN : diff[31:0];
  assign underflow = sat[31];
  assign cnt_tick  = underflow ? sat + {24'd0, period_r} : sat;

  assign rate_period = {q_item.data[6:0], q_item.data[0]};
  assign run_prod    = {5'd0, rate_period} * {8'd0, cfg.clk_mult};

  always_comb begin
    dac_nxt      = dac_r;
    counter_nxt  = counter_r;
    period_nxt   = period_r;
    rst_pend_nxt = rst_pend_r;
    running_nxt  = running_r;
    cpr_nxt      = cpr_r;
    sample_nxt   = '0;
    irq_nxt      = 1'b0;
    cpu_rst_nxt  = 1'b0;
    nmi_nxt      = 1'b0;
    run_nxt      = '0;
    rd_sel_nxt   = (q_item.op == OP_RAM_RD);
    case (q_item.op)
      OP_CPU_RESET: begin
        rst_pend_nxt = 1'b1;
        counter_nxt  = COUNTER_LOAD;
      end
      OP_NMI: begin
        nmi_nxt = 1'b1;
        run_nxt = cpr_r;
      end
      OP_RATE: begin
        period_nxt  = rate_period;
        running_nxt = q_item.data[7];
        cpr_nxt     = run_prod[12] ? RUN_MAX : run_prod[11:0];
      end
      OP_DAC_WR: begin
        dac_nxt = q_item.data;
      end
      OP_TICK: begin
        if (!cfg.paused) begin
          sample_nxt  = cfg.mute ? '0 : prod16;
          counter_nxt = cnt_tick;
          if (underflow) begin
            if (rst_pend_r) begin
              rst_pend_nxt = 1'b0;
              cpu_rst_nxt  = 1'b1;
            end
            if (running_r) begin
              irq_nxt = 1'b1;
              run_nxt = cpr_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dac_r       <= '0;
      counter_r   <= '0;
      period_r    <= '0;
      rst_pend_r  <= 1'b0;
      running_r   <= 1'b0;
      cpr_r       <= RUN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        dac_r      <= dac_nxt;
        counter_r  <= counter_nxt;
        period_r   <= period_nxt;
        rst_pend_r <= rst_pend_nxt;
        running_r  <= running_nxt;
        cpr_r      <= cpr_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_sel_r  <= rd_sel_nxt;
      sample_r  <= sample_nxt;
      irq_r     <= irq_nxt;
      cpu_rst_r <= cpu_rst_nxt;
      nmi_r     <= nmi_nxt;
      run_r     <= run_nxt;
    end
  end

  // shared RAM, one access per word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_item.op == OP_RAM_WR || q_item.op == OP_DAC_WR) begin
        ram_r[ram_addr] <= q_item.data;
      end
      ram_rd_r <= ram_r[ram_addr];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = rd_sel_r ? ram_rd_r : '0;
  assign out_sample_out        = sample_r;
  assign out_irq_request       = irq_r;
  assign out_cpu_reset_request = cpu_rst_r;
  assign out_nmi_request       = nmi_r;
  assign out_run_cycles        = run_r;

endmodule

// ===== src/audio_coprocessor_host_interface.sv =====
// An accepted input word is stored in the queue, then popped into the result register.
// Throughput: one word per cycle unless out_ready stalls the result side; each word
// makes one access to the single port shared RAM and at most one timer update in the back end.
// Reset (rst_n low, synchronous): clears the queue, the result valid flag, timer and
// control state, loads the configuration defaults; RAM and result payload are kept.
module audio_coprocessor_host_interface #(
  parameter int RAM_ADDR_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_action,
  input  logic [15:0]                         in_address,
  input  logic [7:0]                          in_write_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_read_data,
  output logic [15:0]                         out_sample_out,
  output logic                                out_irq_request,
  output logic                                out_cpu_reset_request,
  output logic                                out_nmi_request,
  output logic [11:0]                         out_run_cycles,
  input  logic                                cfg_we,
  input  logic [acphi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acphi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import acphi_pkg::*;

  cfg_t  cfg_r;
  logic  q_full;
  logic  push_valid;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume       <= VOLUME_RESET;
      cfg_r.mute         <= 1'b0;
      cfg_r.paused       <= 1'b0;
      cfg_r.clk_per_tick <= CLK_PER_TICK_RESET;
      cfg_r.clk_mult     <= CLK_MULT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOLUME:       cfg_r.volume       <= cfg_wdata[8:0];
        CFG_MUTE:         cfg_r.mute         <= cfg_wdata[0];
        CFG_PAUSED:       cfg_r.paused       <= cfg_wdata[0];
        CFG_CLK_PER_TICK: cfg_r.clk_per_tick <= cfg_wdata[7:0];
        CFG_CLK_MULT:     cfg_r.clk_mult     <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  acphi_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_write_value (in_write_value),
    .q_full         (q_full),
    .push_valid     (push_valid),
    .push_item      (push_item)
  );

  acphi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  acphi_back #(
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_data         (out_read_data),
    .out_sample_out        (out_sample_out),
    .out_irq_request       (out_irq_request),
    .out_cpu_reset_request (out_cpu_reset_request),
    .out_nmi_request       (out_nmi_request),
    .out_run_cycles        (out_run_cycles)
  );

  // a word is either an NMI or a tick, never both
  a_irq_nmi_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_irq_request && out_nmi_request))
    else $error("irq and nmi requested in one word");

  a_run_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_irq_request && !out_nmi_request) |-> (out_run_cycles == '0))
    else $error("run length without a run request");

  a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_data != '0) |->
      (out_sample_out == '0 && !out_irq_request && !out_cpu_reset_request
       && !out_nmi_request))
    else $error("read data mixed with other result fields");

  // queue only fills when the result side is stalled
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && $past(rst_n)) |-> ($past(out_valid) && !$past(out_ready)))
    else $error("input stalled without output backpressure");

endmodule
